// ===== hdl/brb_pkg.sv =====
// Shared constants, codes and control types of the byte ring buffer.
package brb_pkg;

    // Default sizes
    localparam int DEPTH_DEF   = 4096;
    localparam int MAX_RUN_DEF = 64;

    // Field widths
    localparam int OP_W   = 3;
    localparam int DATA_W = 8;
    localparam int LEN_W  = 13;
    localparam int STAT_W = 2;
    localparam int SEG_W  = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_PULL  = 3'd1;
    localparam logic [OP_W-1:0] OP_COPY  = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK  = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Segment counts reported by peek
    localparam logic [SEG_W-1:0] SEG_NONE = 2'd0;
    localparam logic [SEG_W-1:0] SEG_ONE  = 2'd1;
    localparam logic [SEG_W-1:0] SEG_TWO  = 2'd2;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_COPY
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;         // input item taken this cycle
        logic rd_issue;       // issue one store read of a copy run
        logic out_load_copy;  // load the read byte into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;       // output register can take a new item
        logic copy_run;       // offered item is a copy with at least one byte
        logic all_issued;     // every read of the run has been issued
        logic run_last;       // next byte loaded is the final one of the run
    } dp_stat_t;

endpackage

// ===== hdl/brb_in_if.sv =====
// Input channel of the byte ring buffer: valid/ready with the operation item.
interface brb_in_if;
    logic                          valid;
    logic                          ready;
    logic [brb_pkg::OP_W-1:0]      opcode;
    logic [brb_pkg::DATA_W-1:0]    data_in;
    logic [brb_pkg::LEN_W-1:0]     count;

    modport source (output valid, output opcode, output data_in, output count, input ready);
    modport sink   (input valid, input opcode, input data_in, input count, output ready);
endinterface

// ===== hdl/brb_out_if.sv =====
// Result channel of the byte ring buffer: valid/ready with the result item.
interface brb_out_if;
    logic                          valid;
    logic                          ready;
    logic [brb_pkg::STAT_W-1:0]    status;
    logic [brb_pkg::DATA_W-1:0]    data_out;
    logic                          last;
    logic [brb_pkg::LEN_W-1:0]     fill_count;
    logic [brb_pkg::SEG_W-1:0]     segments;
    logic [brb_pkg::LEN_W-1:0]     first_length;
    logic [brb_pkg::LEN_W-1:0]     second_length;

    modport source (
        output valid, output status, output data_out, output last, output fill_count,
        output segments, output first_length, output second_length, input ready
    );
    modport sink (
        input valid, input status, input data_out, input last, input fill_count,
        input segments, input first_length, input second_length, output ready
    );
endinterface

// ===== hdl/brb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/brb_ctrl.sv =====
// Controller of the byte ring buffer: item acceptance and copy run sequencing.
module brb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  brb_pkg::dp_stat_t  stat,
    output brb_pkg::ctrl_cmd_t cmd
);

    brb_pkg::state_t state_reg, state_next;
    logic            rd_pend_reg, rd_pend_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brb_pkg::S_IDLE:
            begin
                if (in_valid && stat.out_free && stat.copy_run)
                begin
                    state_next = brb_pkg::S_COPY;
                end
            end
            brb_pkg::S_COPY:
            begin
                if (rd_pend_reg && stat.out_free && stat.run_last)
                begin
                    state_next = brb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = brb_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs: handshake and datapath commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            brb_pkg::S_IDLE:
            begin
                in_ready   = stat.out_free;
                cmd.accept = in_valid && stat.out_free;
            end
            brb_pkg::S_COPY:
            begin
                // a read byte waits in the RAM register until the output takes it
                cmd.out_load_copy = rd_pend_reg && stat.out_free;
                cmd.rd_issue      = !stat.all_issued && (!rd_pend_reg || cmd.out_load_copy);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        rd_pend_next = cmd.rd_issue || (rd_pend_reg && !cmd.out_load_copy);
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= brb_pkg::S_IDLE;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

endmodule

// ===== hdl/brb_dp.sv =====
// Datapath of the byte ring buffer: pointers, fill, byte store and result register.
module brb_dp #(
    parameter int DEPTH   = brb_pkg::DEPTH_DEF,
    parameter int MAX_RUN = brb_pkg::MAX_RUN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  brb_pkg::ctrl_cmd_t          cmd,
    output brb_pkg::dp_stat_t           stat,
    input  logic [brb_pkg::OP_W-1:0]    opcode,
    input  logic [brb_pkg::DATA_W-1:0]  data_in,
    input  logic [brb_pkg::LEN_W-1:0]   count,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [brb_pkg::STAT_W-1:0]  status,
    output logic [brb_pkg::DATA_W-1:0]  data_out,
    output logic                        last,
    output logic [brb_pkg::LEN_W-1:0]   fill_count,
    output logic [brb_pkg::SEG_W-1:0]   segments,
    output logic [brb_pkg::LEN_W-1:0]   first_length,
    output logic [brb_pkg::LEN_W-1:0]   second_length
);

    localparam int LW = brb_pkg::LEN_W;
    localparam int PW = $clog2(DEPTH);
    localparam int SW = PW + 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int RW = $clog2(MAX_RUN + 1);
    localparam int CW = (FW > LW) ? FW : LW;

    // Ring state and copy run bookkeeping
    logic [PW-1:0] head_reg, head_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RW-1:0] run_len_reg, run_len_next;
    logic [RW-1:0] issue_cnt_reg, issue_cnt_next;
    logic [RW-1:0] emit_cnt_reg, emit_cnt_next;
    logic          out_valid_reg, out_valid_next;

    // Result register
    logic [brb_pkg::STAT_W-1:0] status_reg, status_next;
    logic [brb_pkg::DATA_W-1:0] data_reg, data_next;
    logic                       last_reg, last_next;
    logic [LW-1:0]              fill_out_reg, fill_out_next;
    logic [brb_pkg::SEG_W-1:0]  segs_reg, segs_next;
    logic [LW-1:0]              first_reg, first_next;
    logic [LW-1:0]              second_reg, second_next;

    logic [CW-1:0]              count_w, fill_w, avail;
    logic [FW-1:0]              n_pull;
    logic [RW-1:0]              copy_len;
    logic                       full;
    logic [SW-1:0]              wr_sum, pull_sum, peek_first_w;
    logic [PW-1:0]              wr_addr, pull_head;
    logic [brb_pkg::SEG_W-1:0]  peek_segs;
    logic [LW-1:0]              peek_first, peek_second;
    logic                       single_load, ram_we;
    logic [brb_pkg::STAT_W-1:0] res_status;
    logic [brb_pkg::SEG_W-1:0]  res_segs;
    logic [LW-1:0]              res_first, res_second;
    logic [brb_pkg::DATA_W-1:0] ram_rdata;

    // Lengths: pull takes min(count, fill), copy also caps at MAX_RUN
    always_comb
    begin
        count_w  = CW'(count);
        fill_w   = CW'(fill_reg);
        avail    = (count_w > fill_w) ? fill_w : count_w;
        n_pull   = FW'(avail);
        copy_len = (avail > CW'(MAX_RUN)) ? RW'(MAX_RUN) : RW'(avail);
        full     = (SW'(fill_reg) >= SW'(DEPTH));
    end

    // Wrapped sums for tail address, new head after pull, and peek split
    always_comb
    begin
        wr_sum    = SW'(head_reg) + SW'(fill_reg);
        wr_addr   = (wr_sum >= SW'(DEPTH)) ? PW'(wr_sum - SW'(DEPTH)) : PW'(wr_sum);
        pull_sum  = SW'(head_reg) + SW'(n_pull);
        pull_head = (pull_sum >= SW'(DEPTH)) ? PW'(pull_sum - SW'(DEPTH)) : PW'(pull_sum);
        peek_first_w = SW'(DEPTH) - SW'(head_reg);
        if (fill_reg == '0)
        begin
            peek_segs   = brb_pkg::SEG_NONE;
            peek_first  = '0;
            peek_second = '0;
        end
        else if (wr_sum <= SW'(DEPTH))
        begin
            peek_segs   = brb_pkg::SEG_ONE;
            peek_first  = LW'(fill_reg);
            peek_second = '0;
        end
        else
        begin
            peek_segs   = brb_pkg::SEG_TWO;
            peek_first  = LW'(peek_first_w);
            peek_second = LW'(SW'(fill_reg) - peek_first_w);
        end
    end

    // Status to the controller
    always_comb
    begin
        stat.out_free   = !out_valid_reg || out_ready;
        stat.copy_run   = (opcode == brb_pkg::OP_COPY) && (copy_len != '0);
        stat.all_issued = (issue_cnt_reg == run_len_reg);
        stat.run_last   = (RW'(emit_cnt_reg + 1'b1) == run_len_reg);
    end

    // Single-result operations, executed in the accept cycle
    always_comb
    begin
        head_next  = head_reg;
        fill_next  = fill_reg;
        ram_we     = 1'b0;
        res_status = brb_pkg::ST_OK;
        res_segs   = brb_pkg::SEG_NONE;
        res_first  = '0;
        res_second = '0;
        if (cmd.accept)
        begin
            case (opcode)
                brb_pkg::OP_PUSH:
                begin
                    if (full)
                    begin
                        res_status = brb_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                brb_pkg::OP_PULL:
                begin
                    head_next = pull_head;
                    fill_next = fill_reg - n_pull;
                end
                brb_pkg::OP_COPY:
                begin
                    if (!stat.copy_run)
                    begin
                        res_status = brb_pkg::ST_EMPTY;
                    end
                end
                brb_pkg::OP_PEEK:
                begin
                    res_segs   = peek_segs;
                    res_first  = peek_first;
                    res_second = peek_second;
                end
                brb_pkg::OP_FLUSH:
                begin
                    head_next = '0;
                    fill_next = '0;
                end
                default:
                begin
                    res_status = brb_pkg::ST_OK;
                end
            endcase
        end
    end

    // Copy run counters and read pointer
    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        run_len_next   = run_len_reg;
        issue_cnt_next = issue_cnt_reg;
        emit_cnt_next  = emit_cnt_reg;
        if (cmd.accept)
        begin
            rd_ptr_next    = head_reg;
            run_len_next   = copy_len;
            issue_cnt_next = '0;
            emit_cnt_next  = '0;
        end
        else
        begin
            if (cmd.rd_issue)
            begin
                rd_ptr_next    = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
                issue_cnt_next = issue_cnt_reg + 1'b1;
            end
            if (cmd.out_load_copy)
            begin
                emit_cnt_next = emit_cnt_reg + 1'b1;
            end
        end
    end

    // Result register loading
    always_comb
    begin
        single_load    = cmd.accept && !stat.copy_run;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        fill_out_next  = fill_out_reg;
        segs_next      = segs_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        if (single_load)
        begin
            out_valid_next = 1'b1;
            status_next    = res_status;
            data_next      = '0;
            last_next      = 1'b1;
            fill_out_next  = LW'(fill_next);
            segs_next      = res_segs;
            first_next     = res_first;
            second_next    = res_second;
        end
        else if (cmd.out_load_copy)
        begin
            out_valid_next = 1'b1;
            status_next    = brb_pkg::ST_OK;
            data_next      = ram_rdata;
            last_next      = stat.run_last;
            fill_out_next  = LW'(fill_reg);
            segs_next      = brb_pkg::SEG_NONE;
            first_next     = '0;
            second_next    = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            rd_ptr_reg    <= '0;
            run_len_reg   <= '0;
            issue_cnt_reg <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            rd_ptr_reg    <= rd_ptr_next;
            run_len_reg   <= run_len_next;
            issue_cnt_reg <= issue_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
        fill_out_reg <= fill_out_next;
        segs_reg     <= segs_next;
        first_reg    <= first_next;
        second_reg   <= second_next;
    end

    // Byte store
    brb_ram #(
        .WIDTH (brb_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (data_in),
        .re    (cmd.rd_issue),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign data_out      = data_reg;
    assign last          = last_reg;
    assign fill_count    = fill_out_reg;
    assign segments      = segs_reg;
    assign first_length  = first_reg;
    assign second_length = second_reg;

endmodule

// ===== hdl/byte_ring_buffer_top.sv =====
// Byte ring buffer: push, pull, copy, peek and flush on a fixed-size byte FIFO.
// Push, pull, peek, flush and an empty copy give their result in the cycle after acceptance.
// Throughput: those items are taken every cycle while the result output is free; a copy
// gives one byte per cycle unless stalled, paced by the store's single registered read port.
// Reset: head pointer, fill and control clear at once; the byte store is not cleared
// and needs no clearing pass, so items are taken right after reset.
module byte_ring_buffer_top #(
    parameter int DEPTH   = brb_pkg::DEPTH_DEF,
    parameter int MAX_RUN = brb_pkg::MAX_RUN_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    brb_in_if.sink    cmd,
    brb_out_if.source result
);

    brb_pkg::ctrl_cmd_t ctl;
    brb_pkg::dp_stat_t  stat;
    logic               in_ready;

    // Controller
    brb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (ctl)
    );

    // Datapath
    brb_dp #(
        .DEPTH   (DEPTH),
        .MAX_RUN (MAX_RUN)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ctl),
        .stat          (stat),
        .opcode        (cmd.opcode),
        .data_in       (cmd.data_in),
        .count         (cmd.count),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .status        (result.status),
        .data_out      (result.data_out),
        .last          (result.last),
        .fill_count    (result.fill_count),
        .segments      (result.segments),
        .first_length  (result.first_length),
        .second_length (result.second_length)
    );

    assign cmd.ready = in_ready;

`ifndef SYNTH
    // A new item and a copy byte never compete for the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.accept && ctl.out_load_copy))
        else $error("item accepted during a copy run");

    // A copy byte is loaded only into a free result register
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load_copy |-> stat.out_free)
        else $error("copy byte overwrote a pending result");

    // No store read beyond the run length
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_issue |-> !stat.all_issued)
        else $error("copy read issued past the run");

    // A single-result item shows its result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && !stat.copy_run) |=> result.valid)
        else $error("single result missing after acceptance");
`endif

endmodule
